/* design/u8u16_pkg.sv */
// Package: shared constants and types for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned RemW  = 2;
  localparam int unsigned Low6W = 6;

  // continuation bytes still expected
  localparam logic [RemW-1:0] REM_NONE = 2'd0;
  localparam logic [RemW-1:0] REM_ONE  = 2'd1;
  localparam logic [RemW-1:0] REM_TWO  = 2'd2;
  localparam logic [RemW-1:0] REM_BAD  = 2'd3;

  localparam logic [ByteW-1:0] LEAD_HI_MASK = 8'h80;
  localparam logic [ByteW-1:0] LEAD3_MASK   = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_BITS   = 8'h1F;
  localparam logic [ByteW-1:0] CONT_BITS    = 8'h3F;
  localparam logic [ByteW-1:0] LEAD3_BITS   = 8'h0F;

  typedef struct packed {
    logic             valid;
    logic [UnitW-1:0] code_unit;
    logic             end_of_string;
  } result_t;

endpackage

/* design/u8u16_ifs.sv */
// Interfaces: byte input channel and code unit result channel.
interface u8u16_in_if;
  logic                            valid;
  logic                            ready;
  logic [u8u16_pkg::ByteW-1:0]     data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8u16_out_if;
  logic                            valid;
  logic                            ready;
  logic [u8u16_pkg::UnitW-1:0]     code_unit;
  logic                            end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

/* design/utf8_to_utf16_decoder_core.sv */
// Top level: UTF-8 byte stream to UTF-16 BMP code units.
// A sequence's last byte passes through the input register, then its code unit through the
// output register, before the code unit can be accepted on the output channel.
// Throughput: one byte per cycle while no held result stalls the output; set by the single
// decode step between the input register and the result register.
// Reset: synchronous active-low rst_n clears both valid flags and the sequence state.
// Middle and lead bytes of multi-byte sequences produce no result.
module utf8_to_utf16_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  u8u16_in_if.sink           in_if,
  u8u16_out_if.source        out_if
);

  logic                        in_vld_r;
  logic [u8u16_pkg::ByteW-1:0] in_byte_r;
  logic                        out_vld_r;
  logic [u8u16_pkg::UnitW-1:0] out_unit_r;
  logic                        out_eos_r;
  logic                        step;
  u8u16_pkg::result_t          result;

  // a byte moves through decode whenever the result register can take its output
  assign step        = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || step;

  u8u16_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= result.valid;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      out_unit_r <= result.code_unit;
      out_eos_r  <= result.end_of_string;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.code_unit     = out_unit_r;
  assign out_if.end_of_string = out_eos_r;

endmodule

/* design/u8u16_decode.sv */
// Decode state: sequence length tracking and code point assembly.
module u8u16_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [u8u16_pkg::ByteW-1:0]    data_byte,
  output u8u16_pkg::result_t             result
);

  logic [u8u16_pkg::RemW-1:0]  rem_r, rem_nxt;
  logic [u8u16_pkg::UnitW-1:0] part_r, part_nxt;
  logic [u8u16_pkg::Low6W-1:0] low6;
  logic [u8u16_pkg::ByteW-1:0] b;

  assign b    = data_byte;
  assign low6 = b[u8u16_pkg::Low6W-1:0] & u8u16_pkg::CONT_BITS[u8u16_pkg::Low6W-1:0];

  always_comb begin
    rem_nxt               = rem_r;
    part_nxt              = part_r;
    result.valid          = 1'b0;
    result.code_unit      = '0;
    result.end_of_string  = 1'b0;
    case (rem_r)
      u8u16_pkg::REM_TWO: begin
        part_nxt = part_r | {4'b0, low6, 6'b0};
        rem_nxt  = u8u16_pkg::REM_ONE;
      end
      u8u16_pkg::REM_ONE: begin
        result.valid     = 1'b1;
        result.code_unit = part_r | {10'b0, low6};
        part_nxt         = '0;
        rem_nxt          = u8u16_pkg::REM_NONE;
      end
      default: begin
        // lead byte (also covers the unreachable count of three)
        rem_nxt = u8u16_pkg::REM_NONE;
        if (b == '0) begin
          part_nxt             = '0;
          result.valid         = 1'b1;
          result.end_of_string = 1'b1;
        end else if ((b & u8u16_pkg::LEAD_HI_MASK) == '0) begin
          part_nxt         = '0;
          result.valid     = 1'b1;
          result.code_unit = {8'b0, b};
        end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_MASK) begin
          part_nxt = {b[3:0] & u8u16_pkg::LEAD3_BITS[3:0], 12'b0};
          rem_nxt  = u8u16_pkg::REM_TWO;
        end else begin
          part_nxt = {5'b0, b[4:0] & u8u16_pkg::LEAD2_BITS[4:0], 6'b0};
          rem_nxt  = u8u16_pkg::REM_ONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= u8u16_pkg::REM_NONE;
      part_r <= '0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

  a_rem_never_bad: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != u8u16_pkg::REM_BAD)
    else $error("continuation count reached an impossible value");

  a_two_then_one: assert property (@(posedge clk) disable iff (!rst_n)
    step && rem_r == u8u16_pkg::REM_TWO |=> rem_r == u8u16_pkg::REM_ONE)
    else $error("middle continuation did not advance the count");

  a_result_ends_seq: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.valid |=> rem_r == u8u16_pkg::REM_NONE && part_r == '0)
    else $error("sequence state not cleared after a result");

  a_low_bits_open: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != u8u16_pkg::REM_NONE |-> part_r[u8u16_pkg::Low6W-1:0] == '0)
    else $error("partial code point has low bits set before the last byte");

endmodule
